// File: rtl/ppp_pkg.sv
// Shared constants for the perspective point projection block.
// Register map, fixed field widths and viewport constants. No dependencies.
package ppp_pkg;

  localparam int DEF_COORD_FRAC_BITS = 16;
  localparam int DEF_COEF_FRAC_BITS  = 12;

  localparam int PT_W    = 32;
  localparam int COEF_W  = 16;
  localparam int TAG_W   = 16;
  localparam int DIM_W   = 15;
  localparam int SCALE_W = 16;
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 6;

  localparam int NDC_LIMIT_BITS = 17;
  localparam int OFFSET_X = 7;
  localparam int OFFSET_Y = 15;
  localparam int LABEL_GAIN = 50;
  localparam int SCALE_FRAC = 14;

  localparam logic [DIM_W-1:0] DEF_WIDTH  = 15'd1920;
  localparam logic [DIM_W-1:0] DEF_HEIGHT = 15'd1080;

  localparam logic [2:0] REG_ROW0   = 3'd0;
  localparam logic [2:0] REG_ROW1   = 3'd1;
  localparam logic [2:0] REG_ROW2   = 3'd2;
  localparam logic [2:0] REG_ROW3   = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

endpackage

// File: rtl/ppp_if.sv
// Stream interfaces for point input and projected result beats.
// Depends on ppp_pkg for field widths.
interface ppp_in_if
  import ppp_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [PT_W-1:0]  point_x;
  logic signed [PT_W-1:0]  point_y;
  logic signed [PT_W-1:0]  point_z;
  logic [TAG_W-1:0]        tag;

  modport source (output valid, point_x, point_y, point_z, tag, input ready);
  modport sink   (input valid, point_x, point_y, point_z, tag, output ready);
endinterface

interface ppp_out_if
  import ppp_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [PT_W-1:0]  screen_x;
  logic signed [PT_W-1:0]  screen_y;
  logic [SCALE_W-1:0]      label_scale;
  logic [TAG_W-1:0]        tag_out;

  modport source (output valid, screen_x, screen_y, label_scale, tag_out, input ready);
  modport sink   (input valid, screen_x, screen_y, label_scale, tag_out, output ready);
endinterface

// File: rtl/perspective_point_projection.sv
// Perspective point projection: 4x4 matrix, w clip test, divide, viewport map.
// Depends on ppp_pkg and the stream interfaces in ppp_if.sv.
//
// One point is accepted every cycle while the output is not stalled. Each point
// passes the restoring divider, which resolves one quotient bit per stage for
// the three clip coordinates in parallel. Points whose clip w is below 0.001
// produce no result beat. The whole pipeline holds while a result waits
// unaccepted; in_pt.ready is then low.
// Matrix and display size are written through the APB port at 8*index.
module perspective_point_projection
  import ppp_pkg::*;
#(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  ppp_in_if.sink            in_pt,
  ppp_out_if.source         out_pt,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int F   = COORD_FRAC_BITS;
  localparam int PW  = COEF_W + PT_W;
  localparam int CW  = PW + 2;
  localparam int Q   = NDC_LIMIT_BITS + F;
  localparam int XW  = CW + Q;
  localparam int NW  = Q + 2;
  localparam int BW  = NW + 1;
  localparam int MW  = BW + DIM_W + 1;
  localparam int SW  = MW + 1;
  localparam int LW  = BW + 7;
  localparam int DS  = Q + 1;
  localparam int NS  = DS + 6;
  localparam int ST_A = DS + 3;
  localparam int ST_B = DS + 4;
  localparam int ST_O = DS + 5;
  localparam int SH_R = (F >= SCALE_FRAC) ? F - SCALE_FRAC : 0;
  localparam int SH_L = (F >= SCALE_FRAC) ? 0 : SCALE_FRAC - F;

  localparam logic signed [CW-1:0] EPS =
    CW'(((64'd1 << (F + COEF_FRAC_BITS)) + 64'd500) / 64'd1000);
  localparam logic signed [BW-1:0] ONE_B = BW'(64'd1 << F);
  localparam logic signed [LW-1:0] ONE_L = LW'(64'd1 << F);
  localparam logic signed [SW-1:0] OFF_X = SW'(64'(OFFSET_X) << F);
  localparam logic signed [SW-1:0] OFF_Y = SW'(64'(OFFSET_Y) << F);
  localparam logic signed [SW-1:0] MAX32 = SW'(64'h7fff_ffff);
  localparam logic signed [SW-1:0] MIN32 = ~MAX32;

  // ---------------- configuration ----------------
  logic [CFG_DW-1:0] row_r [4];
  logic [DIM_W-1:0]  wid_r, hgt_r;
  logic [2:0]        cfg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++) row_r[r] <= CFG_DW'(64'd1 << (COEF_FRAC_BITS + 16 * r));
      wid_r <= DEF_WIDTH;
      hgt_r <= DEF_HEIGHT;
    end else if (cfg_wr) begin
      unique case (cfg_idx) inside
        REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: row_r[cfg_idx[1:0]] <= pwdata;
        REG_WIDTH:  wid_r <= pwdata[DIM_W-1:0];
        REG_HEIGHT: hgt_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx) inside
      REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: prdata = row_r[cfg_idx[1:0]];
      REG_WIDTH:  prdata = CFG_DW'(wid_r);
      REG_HEIGHT: prdata = CFG_DW'(hgt_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [NS-1:0]    vld_r, vld_nxt;
  logic [TAG_W-1:0] tag_r [NS];
  logic             en;

  assign en          = !vld_r[NS-1] || out_pt.ready;
  assign in_pt.ready = en;

  // stage 0: products, stage 1: clip sums, stage 2: magnitudes
  logic signed [PW-1:0] prod_r [4][3];
  logic signed [CW-1:0] c1_r [4];
  logic [CW-1:0]        a2_r [3];
  logic [2:0]           neg2_r;
  logic [CW-1:0]        d2_r;
  logic signed [CW-1:0] c1_nxt [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      c1_nxt[r] = (CW'($signed(row_r[r][48 +: COEF_W])) <<< F);
      for (int j = 0; j < 3; j++) c1_nxt[r] = c1_nxt[r] + CW'(prod_r[r][j]);
    end
  end

  always_comb begin
    vld_nxt    = {vld_r[NS-2:0], in_pt.valid};
    vld_nxt[2] = vld_r[1] && (c1_r[3] >= EPS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_pt.tag;
      for (int s = 1; s < NS; s++) tag_r[s] <= tag_r[s-1];
      for (int r = 0; r < 4; r++) begin
        prod_r[r][0] <= PW'($signed(row_r[r][0 +: COEF_W]) * in_pt.point_x);
        prod_r[r][1] <= PW'($signed(row_r[r][16 +: COEF_W]) * in_pt.point_y);
        prod_r[r][2] <= PW'($signed(row_r[r][32 +: COEF_W]) * in_pt.point_z);
      end
      c1_r <= c1_nxt;
      for (int i = 0; i < 3; i++) begin
        a2_r[i]   <= c1_r[i][CW-1] ? CW'(-c1_r[i]) : CW'(c1_r[i]);
        neg2_r[i] <= c1_r[i][CW-1];
      end
      d2_r <= CW'(c1_r[3]);
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic [XW-1:0] drem_r [DS][3];
  logic [Q-1:0]  dq_r   [DS][3];
  logic [2:0]    dneg_r [DS];
  logic [2:0]    dsat_r [DS];
  logic [CW-1:0] dd_r   [DS];
  logic [XW-1:0] drem_nxt [DS][3];
  logic [Q-1:0]  dq_nxt   [DS][3];
  logic [2:0]    dsat_nxt;

  always_comb begin
    logic [XW-1:0] tsh;
    for (int i = 0; i < 3; i++) begin
      dsat_nxt[i]      = XW'(a2_r[i]) >= (XW'(d2_r) << NDC_LIMIT_BITS);
      drem_nxt[0][i]   = XW'(a2_r[i]) << F;
      dq_nxt[0][i]     = '0;
    end
    for (int g = 1; g < DS; g++) begin
      tsh = XW'(dd_r[g-1]) << (Q - g);
      for (int i = 0; i < 3; i++) begin
        if (drem_r[g-1][i] >= tsh) begin
          drem_nxt[g][i] = drem_r[g-1][i] - tsh;
          dq_nxt[g][i]   = dq_r[g-1][i] | (Q'(1) << (Q - g));
        end else begin
          drem_nxt[g][i] = drem_r[g-1][i];
          dq_nxt[g][i]   = dq_r[g-1][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem_r <= drem_nxt;
      dq_r   <= dq_nxt;
      dneg_r[0] <= neg2_r;
      dsat_r[0] <= dsat_nxt;
      dd_r[0]   <= d2_r;
      for (int g = 1; g < DS; g++) begin
        dneg_r[g] <= dneg_r[g-1];
        dsat_r[g] <= dsat_r[g-1];
        dd_r[g]   <= dd_r[g-1];
      end
    end
  end

  // ---------------- viewport and label ----------------
  logic signed [BW-1:0] bx_r, by_r, bz_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic [F:0]           lc_r;
  logic signed [PT_W-1:0] sx_r, sy_r;
  logic [SCALE_W-1:0]   scale_r;

  logic signed [NW-1:0] ndc_w [3];
  logic signed [LW-1:0] lv_w;
  logic [F:0]           lc_w;
  logic signed [SW-1:0] sxv_w, syv_w;

  always_comb begin
    logic [Q:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag      = dsat_r[DS-1][i] ? ((Q+1)'(1) << Q) : {1'b0, dq_r[DS-1][i]};
      ndc_w[i] = dneg_r[DS-1][i] ? -NW'(mag) : NW'(mag);
    end
    lv_w = LW'(bz_r) * LW'(LABEL_GAIN);
    if (lv_w < 0)          lc_w = '0;
    else if (lv_w > ONE_L) lc_w = (F+1)'(ONE_L);
    else                   lc_w = lv_w[F:0];
    sxv_w = SW'(mx_r >>> 1) - OFF_X;
    syv_w = SW'(my_r >>> 1) - OFF_Y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bx_r <= ONE_B + BW'(ndc_w[0]);
      by_r <= ONE_B - BW'(ndc_w[1]);
      bz_r <= ONE_B - BW'(ndc_w[2]);
      mx_r <= MW'(bx_r) * MW'($signed({1'b0, wid_r}));
      my_r <= MW'(by_r) * MW'($signed({1'b0, hgt_r}));
      lc_r <= lc_w;
      if (sxv_w > MAX32)      sx_r <= MAX32[PT_W-1:0];
      else if (sxv_w < MIN32) sx_r <= MIN32[PT_W-1:0];
      else                    sx_r <= sxv_w[PT_W-1:0];
      if (syv_w > MAX32)      sy_r <= MAX32[PT_W-1:0];
      else if (syv_w < MIN32) sy_r <= MIN32[PT_W-1:0];
      else                    sy_r <= syv_w[PT_W-1:0];
      scale_r <= SCALE_W'(((32'(lc_r) >> SH_R) << SH_L) + 32'd16384);
    end
  end

  assign out_pt.valid       = vld_r[ST_O];
  assign out_pt.screen_x    = sx_r;
  assign out_pt.screen_y    = sy_r;
  assign out_pt.label_scale = scale_r;
  assign out_pt.tag_out     = tag_r[ST_O];

  // ---------------- assertions ----------------
  a_clip_kept: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> ($signed(d2_r) >= EPS))
    else $error("point below clip w threshold reached divider");

  a_scale_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_pt.valid |-> (out_pt.label_scale >= 16'd16384 && out_pt.label_scale <= 16'd32768))
    else $error("label scale out of range");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NS-1] |-> in_pt.ready)
    else $error("input stalled with empty output stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valids moved during stall");

  a_mid_stages: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[ST_A]) |=> vld_r[ST_B])
    else $error("beat lost between viewport stages");

endmodule

// File: verif/tb.sv
// Testbench for perspective_point_projection: random and directed point beats,
// APB register phases, and a self-checking projection predictor.
// Depends on ppp_pkg and the stream interfaces in rtl/ppp_if.sv.
module tb;
  import ppp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic signed [PT_W-1:0] z;
    logic [TAG_W-1:0]       tag;
  } point_t;

  typedef struct packed {
    logic signed [PT_W-1:0] sx;
    logic signed [PT_W-1:0] sy;
    logic [SCALE_W-1:0]     scale;
    logic [TAG_W-1:0]       tag;
  } screen_t;

  localparam longint ONE      = 64'sd1 << DEF_COORD_FRAC_BITS;
  localparam longint CLIP_MIN =
    ((64'sd1 << (DEF_COORD_FRAC_BITS + DEF_COEF_FRAC_BITS)) + 500) / 1000;
  localparam int LATENCY = DEF_COORD_FRAC_BITS + 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  ppp_in_if  in_if();
  ppp_out_if out_if();

  perspective_point_projection dut (
    .clk(clk), .rst_n(rst_n), .in_pt(in_if.sink), .out_pt(out_if.source),
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite), .paddr(cfg_paddr),
    .pwdata(cfg_pwdata), .prdata(cfg_prdata), .pready(cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [CFG_DW-1:0] mat_row [4];
  logic [DIM_W-1:0]  disp_w, disp_h;
  point_t  pending_pts[$];
  screen_t expected_screen[$];
  int      mismatches = 0;
  int      n_accepted = 0;
  bit      no_idle = 1'b0;

  function automatic longint ndc_of(input longint num, input longint den);
    logic [127:0] q;
    longint mag;
    mag = (num < 0) ? -num : num;
    q = (128'(mag) << DEF_COORD_FRAC_BITS) / 128'(den);
    if (q >= (128'd1 << (NDC_LIMIT_BITS + DEF_COORD_FRAC_BITS)))
      q = 128'd1 << (NDC_LIMIT_BITS + DEF_COORD_FRAC_BITS);
    return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit project_point(input point_t p, output screen_t r);
    longint v [4];
    longint c [4];
    longint coef, nx, ny, nz, sx, sy, lv;
    v[0] = p.x; v[1] = p.y; v[2] = p.z; v[3] = ONE;
    for (int i = 0; i < 4; i++) begin
      c[i] = 0;
      for (int j = 0; j < 4; j++) begin
        coef = longint'($signed(mat_row[i][16*j +: 16]));
        c[i] += coef * v[j];
      end
    end
    r = '0;
    if (c[3] < CLIP_MIN) return 1'b0;
    nx = ndc_of(c[0], c[3]);
    ny = ndc_of(c[1], c[3]);
    nz = ndc_of(c[2], c[3]);
    sx = (((ONE + nx) * longint'({49'd0, disp_w})) >>> 1) - OFFSET_X * ONE;
    sy = (((ONE - ny) * longint'({49'd0, disp_h})) >>> 1) - OFFSET_Y * ONE;
    lv = (ONE - nz) * LABEL_GAIN;
    if (lv < 0) lv = 0;
    if (lv > ONE) lv = ONE;
    r.sx = 32'(sat32(sx));
    r.sy = 32'(sat32(sy));
    r.scale = 16'(lv >>> (DEF_COORD_FRAC_BITS - SCALE_FRAC)) + 16'd16384;
    r.tag = p.tag;
    return 1'b1;
  endfunction

  task automatic enqueue_pt(input point_t p);
    pending_pts = {pending_pts, p};
  endtask

  // input driver
  int send_gap = 0;
  always @(posedge clk) begin
    screen_t r;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.point_x <= '0; in_if.point_y <= '0; in_if.point_z <= '0; in_if.tag <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        n_accepted <= n_accepted + 1;
        if (project_point({in_if.point_x, in_if.point_y, in_if.point_z, in_if.tag}, r))
          expected_screen = {expected_screen, r};
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_pts.size() > 0) begin
          point_t p;
          p = pending_pts.pop_front();
          in_if.valid <= 1'b1;
          in_if.point_x <= p.x; in_if.point_y <= p.y; in_if.point_z <= p.z;
          in_if.tag <= p.tag;
          send_gap <= no_idle ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, after the pipeline is well under way
  int  hold_cycles = 0;
  bit  hold_used = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (!hold_used && n_accepted >= 600) begin
      hold_used <= 1'b1;
      hold_cycles <= 300;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // result receiver and checker
  int recv_stall = 0;
  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    screen_t w;
    int      draw;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_screen.size() == 0) begin
          report("unexpected beat, tag", out_if.tag_out, -1);
        end else begin
          w = expected_screen.pop_front();
          if (out_if.screen_x !== w.sx) report("screen_x", out_if.screen_x, w.sx);
          if (out_if.screen_y !== w.sy) report("screen_y", out_if.screen_y, w.sy);
          if (out_if.label_scale !== w.scale) report("label_scale", out_if.label_scale, w.scale);
          if (out_if.tag_out !== w.tag) report("tag_out", out_if.tag_out, w.tag);
        end
      end
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
      end else if (out_if.valid && out_if.ready) begin
        draw = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0);
        recv_stall <= (draw > 0) ? draw - 1 : 0;
        out_if.ready <= (draw == 0);
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= CFG_AW'(8 * idx); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx <= REG_ROW3) mat_row[idx[1:0]] = val;
    else if (idx == REG_WIDTH) disp_w = val[DIM_W-1:0];
    else if (idx == REG_HEIGHT) disp_h = val[DIM_W-1:0];
  endtask

  // wait until the last beat is taken and every expected result is out
  task automatic drain();
    wait (pending_pts.size() == 0);
    @(posedge clk);
    wait (!in_if.valid);
    wait (expected_screen.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [63:0] row4(input logic [15:0] a, b, c, d);
    return {d, c, b, a};
  endfunction

  function automatic point_t pt(input longint x, y, z);
    point_t p;
    p.x = 32'(x); p.y = 32'(y); p.z = 32'(z);
    p.tag = 16'($urandom);
    return p;
  endfunction

  // with frustum set, mostly points in front of a perspective camera, some raw noise; else all raw noise
  function automatic point_t rand_point(input bit frustum);
    longint zz, span;
    if (!frustum || $urandom_range(0, 9) == 0)
      return pt($signed(32'($urandom)), $signed(32'($urandom)), $signed(32'($urandom)));
    zz = -longint'($urandom_range(1, 60 * 65536));
    span = -zz * 2 + 1;
    return pt(longint'($urandom_range(0, 32'(span))) + zz,
              longint'($urandom_range(0, 32'(span))) + zz, zz);
  endfunction

  task automatic rand_phase(input int n, input bit frustum);
    for (int i = 0; i < n; i++) enqueue_pt(rand_point(frustum));
    drain();
  endtask

  initial begin
    mat_row[0] = 64'd4096;
    mat_row[1] = 64'd4096 << 16;
    mat_row[2] = 64'd4096 << 32;
    mat_row[3] = 64'd4096 << 48;
    disp_w = DEF_WIDTH;
    disp_h = DEF_HEIGHT;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset identity matrix: field extremes
    enqueue_pt(pt(0, 0, 0));
    enqueue_pt(pt(2147483647, 2147483647, 2147483647));
    enqueue_pt(pt(-2147483648, -2147483648, -2147483648));
    enqueue_pt(pt(65536, -65536, 65536));
    enqueue_pt(pt(-65536, 65536, -65536));
    enqueue_pt(pt(32768, 32768, 64225));
    enqueue_pt(pt(1, -1, 65536 - 1311));
    drain();

    // w from z alone at unit coefficient: clip threshold and huge ndc
    cfg_write(REG_ROW3, row4(16'h0000, 16'h0000, 16'h0001, 16'h0000));
    cfg_write(REG_ROW0, row4(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF));
    cfg_write(REG_ROW1, row4(16'h0000, 16'h8000, 16'h0000, 16'h8000));
    cfg_write(REG_ROW2, row4(16'h0000, 16'h0000, 16'h1000, 16'h0000));
    cfg_write(REG_WIDTH, 64'hFFFF_FFFF_FFFF_4000);
    cfg_write(REG_HEIGHT, 64'd1);
    cfg_write(3'd6, 64'hDEAD_BEEF_0000_0001);
    cfg_write(3'd7, 64'h0);
    enqueue_pt(pt(1000, 1000, 268434));
    enqueue_pt(pt(1000, 1000, 268435));
    enqueue_pt(pt(1000, 1000, 268436));
    enqueue_pt(pt(2147483647, -2147483648, 268435));
    enqueue_pt(pt(-2147483648, 2147483647, 268435));
    enqueue_pt(pt(5, 5, -1));
    enqueue_pt(pt(0, 0, 2147483647));
    enqueue_pt(pt(-7, 7, 2147483647));
    drain();

    // zero display size
    cfg_write(REG_WIDTH, 64'd0);
    cfg_write(REG_HEIGHT, 64'h8000);
    enqueue_pt(pt(123456, -654321, 300000));
    enqueue_pt(pt(-2147483648, 2147483647, 400000));
    drain();

    // perspective camera, default display; includes the long hold-off
    cfg_write(REG_ROW0, row4(16'd2304, 16'h0000, 16'h0000, 16'h0000));
    cfg_write(REG_ROW1, row4(16'h0000, 16'd4096, 16'h0000, 16'h0000));
    cfg_write(REG_ROW2, row4(16'h0000, 16'h0000, 16'hEFEF, 16'hFCCD));
    cfg_write(REG_ROW3, row4(16'h0000, 16'h0000, 16'hF000, 16'h0000));
    cfg_write(REG_WIDTH, 64'd1920);
    cfg_write(REG_HEIGHT, 64'd1080);
    rand_phase(500, 1'b1);
    no_idle = 1'b1;
    rand_phase(200, 1'b1);
    no_idle = 1'b0;

    // wide field of view, extreme display sizes
    cfg_write(REG_ROW0, row4(16'h7FFF, 16'h0000, 16'h0800, 16'h8000));
    cfg_write(REG_ROW1, row4(16'h0000, 16'h8001, 16'hF800, 16'h7FFF));
    cfg_write(REG_WIDTH, 64'd16384);
    cfg_write(REG_HEIGHT, 64'd1);
    rand_phase(250, 1'b1);
    cfg_write(REG_WIDTH, 64'd1);
    cfg_write(REG_HEIGHT, 64'h7FFF);
    rand_phase(200, 1'b1);

    // random matrices and sizes
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) cfg_write(3'(i), {$urandom, $urandom});
      cfg_write(REG_WIDTH, 64'($urandom_range(0, 32767)));
      cfg_write(REG_HEIGHT, 64'($urandom_range(0, 32767)));
      cfg_write(REG_ROW3, row4(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                               16'($urandom), 16'($urandom_range(0, 32767))));
      rand_phase(120, k[0]);
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
rtl/ppp_pkg.sv
rtl/ppp_if.sv
rtl/perspective_point_projection.sv
verif/tb.sv
